// ----- sv/slcd_pkg.sv -----
// Shared types and constants for the sync length checksum deframer.
`default_nettype none

package slcd_pkg;

    localparam int unsigned SyncBytes   = 4;
    localparam int unsigned HeaderBytes = 6;

    // Configuration register indexes.
    localparam logic REG_SYNC_WORD     = 1'b0;
    localparam logic REG_PAYLOAD_LIMIT = 1'b1;

    localparam logic [15:0] PAYLOAD_LIMIT_RESET = 16'd1024;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Frame verdict codes.
    localparam logic [1:0] STATUS_GOOD     = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

    // Header byte positions.
    localparam logic [2:0] HDR_ADDRESS   = 3'd0;
    localparam logic [2:0] HDR_PACKET_ID = 3'd1;
    localparam logic [2:0] HDR_OFFSET_LO = 3'd2;
    localparam logic [2:0] HDR_OFFSET_HI = 3'd3;
    localparam logic [2:0] HDR_LENGTH_LO = 3'd4;
    localparam logic [2:0] HDR_LENGTH_HI = 3'd5;

    typedef enum logic [3:0] {
        PHASE_HUNT    = 4'b0001,
        PHASE_HEADER  = 4'b0010,
        PHASE_PAYLOAD = 4'b0100,
        PHASE_CHECK   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  dev_addr;
        logic [7:0]  packet_id;
        logic [15:0] frag_offset;
        logic [15:0] payload_length;
        logic [15:0] payload_index;
        logic [7:0]  payload_byte;
        logic [1:0]  frame_status;
    } result_t;

endpackage

`default_nettype wire

// ----- sv/sync_length_checksum_deframer.sv -----
// Top level of the sync word, length and additive checksum deframer.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------
//   input    | in_valid / in_ready        | byte_in
//   output   | out_valid / out_ready      | result_kind .. last
//   config   | cfg_we (no wait)           | cfg_index, cfg_wdata
//
// One byte is taken per cycle while in_ready is high; the parser state updates at the
// accepting edge and any result lands in a two-entry output queue, visible on the next cycle.
// in_ready is low only while both queue entries wait, so a stalled output side
// holds at most two results before the input side stalls.
// Reset returns the parser to hunting with a cleared window and empties the queue.
`default_nettype none

module sync_length_checksum_deframer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  byte_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             result_kind,
    output logic [7:0]       dev_addr,
    output logic [7:0]       packet_id,
    output logic [15:0]      frag_offset,
    output logic [15:0]      payload_length,
    output logic [15:0]      payload_index,
    output logic [7:0]       payload_byte,
    output logic [1:0]       frame_status,
    output logic             last
);

    logic [31:0] sync_word_reg;
    logic [15:0] payload_limit_reg;

    slcd_pkg::phase_t phase_reg, phase_next;
    logic [31:0] window_reg, window_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  address_reg, address_next;
    logic [7:0]  packet_id_reg, packet_id_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  sum_reg, sum_next;

    slcd_pkg::result_t slot_reg [2];
    slcd_pkg::result_t slot_next [2];
    slcd_pkg::result_t res;
    logic [1:0]  fill_reg, fill_next;

    logic        accept;
    logic        push;
    logic        pop;
    logic        wr_pos;
    logic        res_valid;
    logic [15:0] count_inc;
    logic [31:0] shifted;
    logic [15:0] length_full;
    logic        window_full;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign accept    = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign push      = accept && res_valid;
    assign wr_pos    = fill_reg[0] & ~pop;

    assign count_inc   = count_reg + 16'd1;
    assign shifted     = {byte_in, window_reg[31:8]};
    assign length_full = {byte_in, length_reg[7:0]};
    assign window_full = (count_inc >= 16'(slcd_pkg::SyncBytes));

    // Parser: next state and the result, if any, of the byte on the input.
    always_comb
    begin
        phase_next     = phase_reg;
        window_next    = window_reg;
        count_next     = count_reg;
        address_next   = address_reg;
        packet_id_next = packet_id_reg;
        offset_next    = offset_reg;
        length_next    = length_reg;
        sum_next       = sum_reg;
        res_valid      = 1'b0;

        res.kind           = slcd_pkg::KIND_VERDICT;
        res.dev_addr       = address_reg;
        res.packet_id      = packet_id_reg;
        res.frag_offset    = offset_reg;
        res.payload_length = length_reg;
        res.payload_index  = '0;
        res.payload_byte   = '0;
        res.frame_status   = slcd_pkg::STATUS_GOOD;

        case (phase_reg)
            slcd_pkg::PHASE_HEADER:
            begin
                sum_next   = sum_reg + byte_in;
                count_next = count_inc;
                case (count_reg[2:0])
                    slcd_pkg::HDR_ADDRESS:   address_next = byte_in;
                    slcd_pkg::HDR_PACKET_ID: packet_id_next = byte_in;
                    slcd_pkg::HDR_OFFSET_LO: offset_next = {offset_reg[15:8], byte_in};
                    slcd_pkg::HDR_OFFSET_HI: offset_next = {byte_in, offset_reg[7:0]};
                    slcd_pkg::HDR_LENGTH_LO: length_next = {length_reg[15:8], byte_in};
                    default:                 length_next = length_full;
                endcase
                if (count_reg[2:0] == slcd_pkg::HDR_LENGTH_HI)
                begin
                    count_next = '0;
                    if (length_full > payload_limit_reg)
                    begin
                        // The verdict carries the length as received.
                        res_valid          = 1'b1;
                        res.payload_length = length_full;
                        res.frame_status   = slcd_pkg::STATUS_TOO_LONG;
                        phase_next         = slcd_pkg::PHASE_HUNT;
                        window_next        = '0;
                    end
                    else if (length_full == 16'd0)
                    begin
                        phase_next = slcd_pkg::PHASE_CHECK;
                    end
                    else
                    begin
                        phase_next = slcd_pkg::PHASE_PAYLOAD;
                    end
                end
            end
            slcd_pkg::PHASE_PAYLOAD:
            begin
                sum_next          = sum_reg + byte_in;
                res_valid         = 1'b1;
                res.kind          = slcd_pkg::KIND_PAYLOAD;
                res.payload_index = count_reg;
                res.payload_byte  = byte_in;
                count_next        = count_inc;
                if ({1'b0, count_inc} >= {1'b0, length_reg})
                begin
                    phase_next = slcd_pkg::PHASE_CHECK;
                end
            end
            slcd_pkg::PHASE_CHECK:
            begin
                res_valid        = 1'b1;
                res.frame_status = (byte_in == sum_reg) ? slcd_pkg::STATUS_GOOD
                                                        : slcd_pkg::STATUS_MISMATCH;
                phase_next       = slcd_pkg::PHASE_HUNT;
                window_next      = '0;
                count_next       = '0;
            end
            default:
            begin
                // Sliding search; the count saturates once the window is full.
                window_next = shifted;
                if (count_reg < 16'(slcd_pkg::SyncBytes))
                begin
                    count_next = count_inc;
                end
                phase_next = slcd_pkg::PHASE_HUNT;
                if (window_full && (shifted == sync_word_reg))
                begin
                    phase_next     = slcd_pkg::PHASE_HEADER;
                    count_next     = '0;
                    sum_next       = '0;
                    address_next   = '0;
                    packet_id_next = '0;
                    offset_next    = '0;
                    length_next    = '0;
                end
            end
        endcase
    end

    // Output queue: entry 0 is the head shown on the ports.
    always_comb
    begin
        slot_next[0] = slot_reg[0];
        slot_next[1] = slot_reg[1];
        if (pop)
        begin
            slot_next[0] = slot_reg[1];
        end
        if (push)
        begin
            slot_next[wr_pos] = res;
        end
        fill_next = fill_reg - {1'b0, pop} + {1'b0, push};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg     <= '0;
            payload_limit_reg <= slcd_pkg::PAYLOAD_LIMIT_RESET;
            phase_reg         <= slcd_pkg::PHASE_HUNT;
            window_reg        <= '0;
            count_reg         <= '0;
            address_reg       <= '0;
            packet_id_reg     <= '0;
            offset_reg        <= '0;
            length_reg        <= '0;
            sum_reg           <= '0;
            fill_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == slcd_pkg::REG_SYNC_WORD)
                begin
                    sync_word_reg <= cfg_wdata;
                end
                else
                begin
                    payload_limit_reg <= cfg_wdata[15:0];
                end
            end
            if (accept)
            begin
                phase_reg     <= phase_next;
                window_reg    <= window_next;
                count_reg     <= count_next;
                address_reg   <= address_next;
                packet_id_reg <= packet_id_next;
                offset_reg    <= offset_next;
                length_reg    <= length_next;
                sum_reg       <= sum_next;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg[0] <= slot_next[0];
        slot_reg[1] <= slot_next[1];
    end

    assign result_kind    = slot_reg[0].kind;
    assign dev_addr       = slot_reg[0].dev_addr;
    assign packet_id      = slot_reg[0].packet_id;
    assign frag_offset    = slot_reg[0].frag_offset;
    assign payload_length = slot_reg[0].payload_length;
    assign payload_index  = slot_reg[0].payload_index;
    assign payload_byte   = slot_reg[0].payload_byte;
    assign frame_status   = slot_reg[0].frame_status;
    assign last           = slot_reg[0].kind;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the sync word, length and checksum deframer.
module tb;
    import slcd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned RANDOM_ITEMS = 700;
    localparam int unsigned PHASES       = 10;
    localparam int unsigned TABLE_ROWS   = 33;

    typedef struct packed {
        logic        kind;
        logic [7:0]  address;
        logic [7:0]  pkt_id;
        logic [15:0] offset;
        logic [15:0] length;
        logic [15:0] index;
        logic [7:0]  value;
        logic [1:0]  status;
        logic        last;
    } deframe_out_t;

    // A row with typed set carries the result that its byte must produce.
    typedef struct packed {
        logic [7:0] value;
        logic       typed;
        logic       kind;
        logic [1:0] status;
    } table_row_t;

    localparam table_row_t STIM_TABLE [TABLE_ROWS] = '{
        // Zero sync word straight after reset, then a one byte payload with a bad checksum.
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'hFF, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'hFF, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'hFF, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'hFF, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h01, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'hFF, 1'b1, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b1, KIND_VERDICT, STATUS_MISMATCH},
        // The zero checksum byte above must not count toward this sync word.
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h5A, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'hA5, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'hFF, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'hFF, 1'b1, KIND_VERDICT, STATUS_TOO_LONG},
        // Empty payload goes straight to a good checksum.
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b0, KIND_PAYLOAD, STATUS_GOOD},
        '{8'h00, 1'b1, KIND_VERDICT, STATUS_GOOD}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  byte_in;
    logic        out_valid;
    logic        out_ready;
    logic        result_kind;
    logic [7:0]  dev_addr;
    logic [7:0]  packet_id;
    logic [15:0] frag_offset;
    logic [15:0] payload_length;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
    logic [1:0]  frame_status;
    logic        last;

    sync_length_checksum_deframer u_top (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Parser copy: configuration and state as the block holds them.
    logic [31:0] sync_cfg;
    logic [15:0] limit_cfg;
    phase_t      ph;
    logic [31:0] sync_window;
    logic [15:0] field_count;
    logic [7:0]  held_addr;
    logic [7:0]  held_pid;
    logic [15:0] held_off;
    logic [15:0] held_len;
    logic [7:0]  byte_sum;

    deframe_out_t frame_results [$];
    deframe_out_t last_pred;
    bit           last_has;
    int unsigned  error_total = 0;
    int unsigned  sent_items = 0;
    int unsigned  quiet_left = 0;
    int unsigned  cycle_count = 0;

    function automatic void restart_hunt();
        ph          = PHASE_HUNT;
        sync_window = '0;
        field_count = '0;
    endfunction

    function automatic deframe_out_t pack_result(input logic kind, input logic [15:0] idx,
                                                 input logic [7:0] value,
                                                 input logic [1:0] status);
        deframe_out_t r;
        r.kind    = kind;
        r.address = held_addr;
        r.pkt_id  = held_pid;
        r.offset  = held_off;
        r.length  = held_len;
        r.index   = idx;
        r.value   = value;
        r.status  = status;
        r.last    = kind;
        return r;
    endfunction

    // Advances the parser copy by one byte; returns 1 when the byte yields a result.
    function automatic bit deframe_step(input logic [7:0] b, output deframe_out_t r);
        bit got;
        got = 1'b0;
        r   = '0;
        case (ph)
            PHASE_HEADER:
            begin
                byte_sum = byte_sum + b;
                case (field_count)
                    HDR_ADDRESS:   held_addr = b;
                    HDR_PACKET_ID: held_pid = b;
                    HDR_OFFSET_LO: held_off[7:0] = b;
                    HDR_OFFSET_HI: held_off[15:8] = b;
                    HDR_LENGTH_LO: held_len[7:0] = b;
                    default:       held_len[15:8] = b;
                endcase
                field_count = field_count + 16'd1;
                if (field_count >= HeaderBytes)
                begin
                    if (held_len > limit_cfg)
                    begin
                        r   = pack_result(KIND_VERDICT, 16'd0, 8'd0, STATUS_TOO_LONG);
                        got = 1'b1;
                        restart_hunt();
                    end
                    else
                    begin
                        field_count = '0;
                        ph = (held_len == 16'd0) ? PHASE_CHECK : PHASE_PAYLOAD;
                    end
                end
            end
            PHASE_PAYLOAD:
            begin
                byte_sum = byte_sum + b;
                r   = pack_result(KIND_PAYLOAD, field_count, b, STATUS_GOOD);
                got = 1'b1;
                field_count = field_count + 16'd1;
                if (field_count >= held_len)
                    ph = PHASE_CHECK;
            end
            PHASE_CHECK:
            begin
                r   = pack_result(KIND_VERDICT, 16'd0, 8'd0,
                                  (b == byte_sum) ? STATUS_GOOD : STATUS_MISMATCH);
                got = 1'b1;
                restart_hunt();
            end
            default:
            begin
                sync_window = {b, sync_window[31:8]};
                if (field_count < SyncBytes)
                    field_count = field_count + 16'd1;
                if (field_count >= SyncBytes && sync_window == sync_cfg)
                begin
                    ph          = PHASE_HEADER;
                    field_count = '0;
                    byte_sum    = '0;
                    held_addr   = '0;
                    held_pid    = '0;
                    held_off    = '0;
                    held_len    = '0;
                end
                else
                    ph = PHASE_HUNT;
            end
        endcase
        return got;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_total++;
        end
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Mostly short payloads, some empty, a few over the limit.
    function automatic logic [15:0] pick_length(input logic [15:0] lim);
        int unsigned r;
        int unsigned cap;
        int unsigned lim_i;
        int unsigned room;
        r     = $urandom_range(0, 99);
        lim_i = lim;
        if (r < 14 && lim != 16'hFFFF)
        begin
            room = 65534 - lim_i;
            if (r < 7)
                return 16'(lim_i + 1 + $urandom_range(0, (room < 4) ? room : 4));
            return 16'($urandom_range(lim_i + 1, 65535));
        end
        if (r < 28 || lim == 16'd0)
            return 16'd0;
        cap = (r < 96) ? 12 : 160;
        if (lim_i < cap)
            cap = lim_i;
        return 16'($urandom_range(1, cap));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (quiet_left != 0)
        begin
            gap = 0;
            quiet_left--;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(0, 99) < 3)
                quiet_left = $urandom_range(20, 60);
        end
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        sent_items++;
        last_has = deframe_step(b, last_pred);
        if (last_has)
            frame_results.push_back(last_pred);
    endtask

    task automatic go_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (frame_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        if (idx == REG_SYNC_WORD)
            sync_cfg = data;
        else
            limit_cfg = data[15:0];
    endtask

    task automatic send_frame();
        int unsigned r;
        int unsigned n;
        int unsigned k;
        logic [15:0] length;
        // Flush whatever is left of a frame that was cut short.
        while (ph != PHASE_HUNT)
            send_byte(8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(8'($urandom));
        end
        else if (r < 18)
        begin
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++)
                send_byte(sync_cfg[8*k +: 8]);
            send_byte(8'($urandom));
        end
        else
        begin
            // A leading fragment of the sync word exercises the sliding search.
            if (r < 30 && sync_cfg[15:0] != sync_cfg[31:16])
            begin
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                    send_byte(sync_cfg[8*k +: 8]);
            end
            else if (r < 40)
            begin
                n = $urandom_range(1, 3);
                repeat (n) send_byte(8'($urandom));
            end
            for (k = 0; k < SyncBytes; k++)
                send_byte(sync_cfg[8*k +: 8]);
            length = pick_length(limit_cfg);
            repeat (4) send_byte(8'($urandom));
            send_byte(length[7:0]);
            send_byte(length[15:8]);
            if (ph == PHASE_PAYLOAD)
            begin
                n = length;
                if (n >= 2 && $urandom_range(0, 19) == 0)
                    n = n / 2;
                for (k = 0; k < n; k++)
                    send_byte(8'($urandom));
            end
            if (ph == PHASE_CHECK)
                send_byte(($urandom_range(0, 9) < 7) ? byte_sum : 8'($urandom));
        end
    endtask

    initial
    begin
        int unsigned run;
        out_ready = 1'b0;
        forever
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                run = $urandom_range(1, 40);
                @(negedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                run = pick_gap();
                if (run == 0)
                    run = 1;
                @(negedge clk);
                out_ready <= 1'b0;
            end
            repeat (run - 1) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        deframe_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                error_total++;
            end
            else
            begin
                want = frame_results.pop_front();
                check_field("result_kind", want.kind, result_kind);
                check_field("dev_addr", want.address, dev_addr);
                check_field("packet_id", want.pkt_id, packet_id);
                check_field("frag_offset", want.offset, frag_offset);
                check_field("payload_length", want.length, payload_length);
                check_field("payload_index", want.index, payload_index);
                check_field("payload_byte", want.value, payload_byte);
                check_field("frame_status", want.status, frame_status);
                check_field("last", want.last, last);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        table_row_t  row;
        int unsigned p;
        logic [31:0] sync_pick;
        logic [15:0] limit_pick;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_SYNC_WORD;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        byte_in   = '0;
        sync_cfg  = '0;
        limit_cfg = PAYLOAD_LIMIT_RESET;
        restart_hunt();
        held_addr = '0;
        held_pid  = '0;
        held_off  = '0;
        held_len  = '0;
        byte_sum  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < TABLE_ROWS; i++)
        begin
            row = STIM_TABLE[i];
            send_byte(row.value);
            if (row.typed)
            begin
                check_field("table result present", 32'd1, {31'd0, last_has});
                check_field("table result_kind", row.kind, last_pred.kind);
                check_field("table frame_status", row.status, last_pred.status);
            end
        end

        for (p = 0; p < PHASES; p++)
        begin
            go_idle();
            case (p % 3)
                0:       sync_pick = $urandom;
                1:       sync_pick = 32'hFFFF_FFFF;
                default: sync_pick = 32'h0000_0000;
            endcase
            case (p % 4)
                0:       limit_pick = 16'd0;
                1:       limit_pick = 16'hFFFF;
                2:       limit_pick = 16'($urandom_range(1, 40));
                default: limit_pick = PAYLOAD_LIMIT_RESET;
            endcase
            write_reg(REG_SYNC_WORD, sync_pick);
            write_reg(REG_PAYLOAD_LIMIT, {16'd0, limit_pick});
            @(negedge clk);
            cfg_we <= 1'b0;
            while (sent_items < (p + 1) * RANDOM_ITEMS / PHASES)
                send_frame();
        end

        go_idle();
        repeat (10) @(posedge clk);
        if (error_total == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/slcd_pkg.sv
sv/sync_length_checksum_deframer.sv
tb/tb.sv
